/* hw/rtl/ecdf_pkg.sv */
// ----------------------------------------------------------------------------
// ecdf_pkg - shared types and constants for the empirical cdf sampler
// table sizes, field widths, item kinds, sequencer states and the
// structs that run between the table, the divider and the top level
// ----------------------------------------------------------------------------
package ecdf_pkg;

   localparam int TABLE_DEPTH = 65536;
   localparam int INDEX_BITS  = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS  = INDEX_BITS + 1;
   localparam int VALUE_BITS  = 24;
   localparam int PROB_BITS   = 20;
   localparam int FRAC_BITS   = 8;
   localparam int RESULT_BITS = VALUE_BITS + FRAC_BITS;
   localparam int PROD_BITS   = PROB_BITS + VALUE_BITS;
   localparam int STEP_BITS   = $clog2(RESULT_BITS);

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_DRAW   = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SEARCH,
      ST_UPPER,
      ST_LOWER,
      ST_MUL,
      ST_DIV_START,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  en;
      logic [INDEX_BITS-1:0] addr;
      logic [VALUE_BITS-1:0] value;
      logic [PROB_BITS-1:0]  prob;
   } tbl_wr_type;

   typedef struct packed {
      logic done;
      logic rem_nz;
   } div_status_type;

endpackage

/* hw/rtl/ecdf_table.sv */
// ----------------------------------------------------------------------------
// ecdf_table - point storage
// two memories (probability and value), each with one write and one read port,
// sharing one write address and one read address, read data registered
// ----------------------------------------------------------------------------
module ecdf_table
   import ecdf_pkg::*;
(
   input  logic                  clock,
   input  tbl_wr_type            wr,
   input  logic [INDEX_BITS-1:0] rd_addr,
   output logic [PROB_BITS-1:0]  prob_rd,
   output logic [VALUE_BITS-1:0] value_rd
);

   logic [PROB_BITS-1:0]  prob_mem  [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] value_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         prob_mem[wr.addr]  <= wr.prob;
         value_mem[wr.addr] <= wr.value;
      end
   end

   always_ff @(posedge clock) begin
      prob_rd  <= prob_mem[rd_addr];
      value_rd <= value_mem[rd_addr];
   end

endmodule

/* hw/rtl/ecdf_divider.sv */
// ----------------------------------------------------------------------------
// ecdf_divider - serial restoring divider
// one quotient bit per cycle; the upper dividend part must already be
// below the divisor so the quotient fits in RESULT_BITS
// ----------------------------------------------------------------------------
module ecdf_divider
   import ecdf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [PROB_BITS-1:0]   num_hi,
   input  logic [RESULT_BITS-1:0] num_lo,
   input  logic [PROB_BITS-1:0]   divisor,
   output logic [RESULT_BITS-1:0] quotient,
   output div_status_type         status
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_BITS-1:0]   cnt_ff, cnt_in;
   logic [PROB_BITS-1:0]   rem_ff, rem_in;
   logic [RESULT_BITS-1:0] quo_ff, quo_in;
   logic [PROB_BITS-1:0]   div_ff, div_in;
   logic [PROB_BITS:0]     trial;
   logic [PROB_BITS:0]     diff;
   logic                   ge;

   assign trial = {rem_ff, quo_ff[RESULT_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num_hi;
         quo_in  = num_lo;
         div_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits suffice
         rem_in = ge ? diff[PROB_BITS-1:0] : trial[PROB_BITS-1:0];
         quo_in = {quo_ff[RESULT_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_BITS'(RESULT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient      = quo_ff;
   assign status.done   = done_ff;
   assign status.rem_nz = rem_ff != '0;

endmodule

/* hw/rtl/empirical_cdf_sampler_core.sv */
// ----------------------------------------------------------------------------
// empirical_cdf_sampler_core - inverse transform sampling from a cdf table
// channel  dir  tdata                                   tuser
// req      in   entry_value, entry_prob, draw_uniform   kind
// rsp      out  sample_value, hit_index                 table_empty
// clear and append complete when accepted; a draw runs, at most, through
// one table read per binary search step (up to 16), a few reads around the
// hit, one multiply, then the serial divider
// req_tready is high only while the sequencer is idle
// a finished word waits in the output register; the next item is taken meanwhile
// reset empties the table (count only); memory contents are not cleared
// ----------------------------------------------------------------------------
module empirical_cdf_sampler_core
   import ecdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // entry_value[23:0], entry_prob[43:24], draw_uniform[63:44]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // sample_value[31:0], hit_index[47:32]
   output logic        rsp_tuser    // table_empty[0]
);

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [PROB_BITS-1:0]   u_ff, u_in;
   logic [INDEX_BITS-1:0]  lo_ff, lo_in;
   logic [INDEX_BITS-1:0]  hi_ff, hi_in;
   logic [INDEX_BITS-1:0]  hit_ff, hit_in;
   logic [PROB_BITS-1:0]   p2_ff, p2_in;
   logic [VALUE_BITS-1:0]  y2_ff, y2_in;
   logic [PROB_BITS-1:0]   dx_ff, dx_in;
   logic [PROB_BITS-1:0]   dp_ff, dp_in;
   logic [VALUE_BITS-1:0]  dy_ff, dy_in;
   logic                   neg_ff, neg_in;
   logic [RESULT_BITS-1:0] base_ff, base_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [RESULT_BITS-1:0] res_ff, res_in;
   logic                   empty_ff, empty_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [INDEX_BITS-1:0]  rsp_hit_ff, rsp_hit_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   logic                   accept;
   kind_type               kind;
   logic [VALUE_BITS-1:0]  in_value;
   logic [PROB_BITS-1:0]   in_prob;
   logic [PROB_BITS-1:0]   in_uniform;
   logic                   rsp_free;

   tbl_wr_type             tbl_wr;
   logic [INDEX_BITS-1:0]  rd_addr;
   logic [PROB_BITS-1:0]   prob_rd;
   logic [VALUE_BITS-1:0]  value_rd;

   logic                   div_start;
   logic [RESULT_BITS-1:0] quotient;
   div_status_type         div_status;

   logic [INDEX_BITS-1:0]  s_lo, s_hi;
   logic [INDEX_BITS:0]    s_sum;
   logic [INDEX_BITS-1:0]  s_mid;
   logic [INDEX_BITS-1:0]  f_hi;
   logic [INDEX_BITS:0]    f_sum;
   logic [RESULT_BITS-1:0] q_up;

   assign accept     = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign in_value   = req_tdata[VALUE_BITS-1:0];
   assign in_prob    = req_tdata[43:24];
   assign in_uniform = req_tdata[63:44];
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = state_ff == ST_IDLE;

   ecdf_table u_table (
      .clock    (clock),
      .wr       (tbl_wr),
      .rd_addr  (rd_addr),
      .prob_rd  (prob_rd),
      .value_rd (value_rd)
   );

   ecdf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num_hi   (prod_ff[PROD_BITS-1 -: PROB_BITS]),
      .num_lo   ({prod_ff[PROD_BITS-PROB_BITS-1:0], {FRAC_BITS{1'b0}}}),
      .divisor  (dp_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   // midpoint issued last cycle, rebuilt from the current bounds
   function automatic logic [INDEX_BITS-1:0] s_mid_prev();
      logic [INDEX_BITS:0] sum;
      sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      return sum[INDEX_BITS:1];
   endfunction

   // search step on the word just read at the last midpoint
   always_comb begin
      s_lo = lo_ff;
      s_hi = hi_ff;
      if (u_ff > prob_rd) begin
         s_lo = hi_ff == lo_ff ? lo_ff : INDEX_BITS'({1'b0, s_mid_prev()} + 1'b1);
      end else begin
         s_hi = s_mid_prev();
      end
      s_sum = {1'b0, s_lo} + {1'b0, s_hi};
      s_mid = s_sum[INDEX_BITS:1];
   end

   assign f_hi  = INDEX_BITS'(count_ff - 1'b1);
   assign f_sum = {1'b0, f_hi} + {{INDEX_BITS{1'b0}}, 1'b1};
   assign q_up  = quotient + {{(RESULT_BITS-1){1'b0}}, div_status.rem_nz};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && kind == KIND_DRAW) begin
               state_in = count_ff == '0 ? ST_DONE : ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (u_ff <= prob_rd || count_ff < COUNT_BITS'(2)) begin
               state_in = ST_DONE;
            end else if (count_ff == COUNT_BITS'(2)) begin
               state_in = ST_UPPER;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (s_lo >= s_hi) begin
               state_in = ST_UPPER;
            end
         end
         ST_UPPER: begin
            state_in = u_ff >= prob_rd ? ST_DONE : ST_LOWER;
         end
         ST_LOWER: begin
            state_in = u_ff <= prob_rd ? ST_DONE : ST_MUL;
         end
         ST_MUL:       state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV;
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      u_in         = u_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      hit_in       = hit_ff;
      p2_in        = p2_ff;
      y2_in        = y2_ff;
      dx_in        = dx_ff;
      dp_in        = dp_ff;
      dy_in        = dy_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_empty_in = rsp_empty_ff;
      tbl_wr.en    = 1'b0;
      tbl_wr.addr  = count_ff[INDEX_BITS-1:0];
      tbl_wr.value = in_value;
      tbl_wr.prob  = in_prob;
      rd_addr      = '0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (kind)
                  KIND_CLEAR: count_in = '0;
                  KIND_APPEND: begin
                     if (count_ff < COUNT_BITS'(TABLE_DEPTH)) begin
                        tbl_wr.en = 1'b1;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  KIND_DRAW: begin
                     u_in     = in_uniform;
                     empty_in = count_ff == '0;
                     res_in   = '0;
                     hit_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_FIRST: begin
            res_in = {value_rd, {FRAC_BITS{1'b0}}};
            hit_in = '0;
            lo_in  = INDEX_BITS'(1);
            hi_in  = f_hi;
            if (count_ff == COUNT_BITS'(2)) begin
               rd_addr = INDEX_BITS'(1);
            end else begin
               rd_addr = f_sum[INDEX_BITS:1];
            end
         end
         ST_SEARCH: begin
            lo_in = s_lo;
            hi_in = s_hi;
            rd_addr = s_lo >= s_hi ? s_lo : s_mid;
         end
         ST_UPPER: begin
            hit_in  = lo_ff;
            p2_in   = prob_rd;
            y2_in   = value_rd;
            res_in  = {value_rd, {FRAC_BITS{1'b0}}};
            rd_addr = lo_ff - 1'b1;
         end
         ST_LOWER: begin
            res_in  = {value_rd, {FRAC_BITS{1'b0}}};
            base_in = {value_rd, {FRAC_BITS{1'b0}}};
            dx_in   = u_ff - prob_rd;
            dp_in   = p2_ff - prob_rd;
            neg_in  = y2_ff < value_rd;
            dy_in   = y2_ff < value_rd ? value_rd - y2_ff : y2_ff - value_rd;
         end
         ST_MUL: begin
            prod_in = PROD_BITS'(dx_ff) * PROD_BITS'(dy_ff);
         end
         ST_DIV_START: div_start = 1'b1;
         ST_DIV: begin
            if (div_status.done) begin
               // falling step rounds the fraction up before it is taken off
               res_in = neg_ff ? base_ff - q_up : base_ff + quotient;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_hit_in   = hit_ff;
               rsp_empty_in = empty_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      u_ff         <= u_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      hit_ff       <= hit_in;
      p2_ff        <= p2_in;
      y2_ff        <= y2_in;
      dx_ff        <= dx_in;
      dp_ff        <= dp_in;
      dy_ff        <= dy_in;
      neg_ff       <= neg_in;
      base_ff      <= base_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      empty_ff     <= empty_in;
      rsp_value_ff <= rsp_value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_hit_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> lo_ff < hi_ff)
      else $error("search bounds crossed");

   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      accept && kind == KIND_DRAW |=> !req_tready)
      else $error("draw accepted without leaving idle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_value_ff == '0 && rsp_hit_ff == '0)
      else $error("empty table word carries a value");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

endmodule
